// ===== hw/rtl/kett_pkg.sv =====
// Package for the keyed event tally table: operation and outcome codes,
// controller states and the command/status structs between controller and datapath.
// No dependencies.
package kett_pkg;

   // Fixed field widths of the request and response transactions
   localparam int OP_W     = 2;
   localparam int REASON_W = 3;
   localparam int TAG_W    = 64;
   localparam int INDEX_W  = 5;
   localparam int USED_W   = 6;
   localparam int TALLY_W  = 32;

   typedef enum logic [OP_W-1:0] {
      OP_RECORD = 2'd0,
      OP_READ   = 2'd1,
      OP_CLEAR  = 2'd2,
      OP_NOP    = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      OUT_EXISTING   = 2'd0,
      OUT_NEW        = 2'd1,
      OUT_FULL       = 2'd2,
      OUT_BAD_REASON = 2'd3
   } outcome_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DISPATCH,
      ST_SCAN,
      ST_RESP
   } state_type;

   // Controller -> datapath
   typedef struct packed {
      logic        load;        // latch request fields
      logic        clear;       // empty table, zero total and flag
      logic        scan_start;  // reset scan pointer
      logic        scan_step;   // issue next slot read
      logic        read_issue;  // read the slot named by the request
      logic        bump;        // increment tally of the hit slot
      logic        append;      // store new pair at the end
      logic        drop;        // table full: count event, set flag
      logic        outcome_wr;
      outcome_type outcome;
      logic        respond;     // register the response transaction
   } cmd_type;

   // Datapath -> controller
   typedef struct packed {
      op_type op;
      logic   reason_ok;
      logic   hit;
      logic   scan_done;
      logic   full;
   } stat_type;

endpackage

// ===== hw/rtl/keyed_event_tally_table.sv =====
// Keyed event tally table: tallies events per (reason, source tag) pair.
// Top level; instantiates kett_ctrl and kett_dp, depends on kett_pkg.
//
// Usage:
//  - Request channel: drive req_* and raise start; the transaction is taken at
//    a rising edge where start is high and busy is low. busy stays high until
//    the response is issued.
//  - Response channel: rsp_strobe is high for exactly one cycle with all rsp_*
//    fields valid; the receiver must take it in that cycle.
//  - Read, clear, bad-reason and unused operations go from dispatch straight to
//    the response. A valid record first scans the entries in use, stopping at a
//    hit, so its time grows with U, the entries in use, and with the hit slot.
//  - The record time is set by the slot scan, one memory read per cycle
//    through the single registered read port, plus dispatch and response.
//  - busy is low again in the strobe cycle, so the next request is taken at
//    the edge that ends it.
//  - Reset empties the table and zeroes the total and the overflow flag;
//    slot contents are not cleared, only entries below the used count are read.
module keyed_event_tally_table #(
   parameter int TABLE_SLOTS  = 32,
   parameter int REASON_COUNT = 5,
   parameter int TAG_BITS     = 64
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [kett_pkg::OP_W-1:0]     req_operation,
   input  logic [kett_pkg::REASON_W-1:0] req_reason_code,
   input  logic [kett_pkg::TAG_W-1:0]    req_source_tag,
   input  logic [kett_pkg::INDEX_W-1:0]  req_entry_index,
   output logic                          rsp_strobe,
   output logic [1:0]                    rsp_outcome,
   output logic                          rsp_entry_valid,
   output logic [kett_pkg::REASON_W-1:0] rsp_entry_reason,
   output logic [kett_pkg::TAG_W-1:0]    rsp_entry_source,
   output logic [kett_pkg::TALLY_W-1:0]  rsp_entry_tally,
   output logic [kett_pkg::USED_W-1:0]   rsp_entries_used,
   output logic [kett_pkg::TALLY_W-1:0]  rsp_grand_total,
   output logic                          rsp_overflowed
);
   import kett_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   kett_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .stat  (stat),
      .busy  (busy),
      .cmd   (cmd)
   );

   kett_dp #(
      .TABLE_SLOTS  (TABLE_SLOTS),
      .REASON_COUNT (REASON_COUNT),
      .TAG_BITS     (TAG_BITS)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .stat             (stat),
      .req_operation    (req_operation),
      .req_reason_code  (req_reason_code),
      .req_source_tag   (req_source_tag),
      .req_entry_index  (req_entry_index),
      .rsp_strobe       (rsp_strobe),
      .rsp_outcome      (rsp_outcome),
      .rsp_entry_valid  (rsp_entry_valid),
      .rsp_entry_reason (rsp_entry_reason),
      .rsp_entry_source (rsp_entry_source),
      .rsp_entry_tally  (rsp_entry_tally),
      .rsp_entries_used (rsp_entries_used),
      .rsp_grand_total  (rsp_grand_total),
      .rsp_overflowed   (rsp_overflowed)
   );

endmodule

// ===== hw/rtl/kett_ctrl.sv =====
// Controller of the keyed event tally table: sequences dispatch, slot scan,
// update and response. Depends on kett_pkg.
module kett_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  kett_pkg::stat_type stat,
   output logic               busy,
   output kett_pkg::cmd_type  cmd
);
   import kett_pkg::*;

   state_type state_ff, state_in;

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) state_in = ST_DISPATCH;
         end
         ST_DISPATCH: begin
            if (stat.op == OP_RECORD && stat.reason_ok) state_in = ST_SCAN;
            else state_in = ST_RESP;
         end
         ST_SCAN: begin
            if (stat.hit || stat.scan_done) state_in = ST_RESP;
         end
         ST_RESP: begin
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Outputs
   always_comb begin
      cmd = '0;
      cmd.outcome = OUT_EXISTING;
      busy = (state_ff != ST_IDLE);
      unique case (state_ff)
         ST_IDLE: begin
            cmd.load = start;
         end
         ST_DISPATCH: begin
            unique case (stat.op)
               OP_RECORD: begin
                  if (stat.reason_ok) begin
                     cmd.scan_start = 1'b1;
                  end else begin
                     cmd.outcome_wr = 1'b1;
                     cmd.outcome    = OUT_BAD_REASON;
                  end
               end
               OP_READ:  cmd.read_issue = 1'b1;
               OP_CLEAR: cmd.clear = 1'b1;
               default: ;
            endcase
         end
         ST_SCAN: begin
            if (stat.hit) begin
               cmd.bump = 1'b1;
            end else if (stat.scan_done) begin
               cmd.outcome_wr = 1'b1;
               if (stat.full) begin
                  cmd.drop    = 1'b1;
                  cmd.outcome = OUT_FULL;
               end else begin
                  cmd.append  = 1'b1;
                  cmd.outcome = OUT_NEW;
               end
            end else begin
               cmd.scan_step = 1'b1;
            end
         end
         ST_RESP: begin
            cmd.respond = 1'b1;
         end
         default: ;
      endcase
   end

endmodule

// ===== hw/rtl/kett_dp.sv =====
// Datapath of the keyed event tally table: request latch, slot memory with
// registered read, scan pointer, counters and response registers. Depends on kett_pkg.
module kett_dp #(
   parameter int TABLE_SLOTS  = 32,
   parameter int REASON_COUNT = 5,
   parameter int TAG_BITS     = 64
) (
   input  logic                               clock,
   input  logic                               reset,
   input  kett_pkg::cmd_type                  cmd,
   output kett_pkg::stat_type                 stat,
   input  logic [kett_pkg::OP_W-1:0]          req_operation,
   input  logic [kett_pkg::REASON_W-1:0]      req_reason_code,
   input  logic [kett_pkg::TAG_W-1:0]         req_source_tag,
   input  logic [kett_pkg::INDEX_W-1:0]       req_entry_index,
   output logic                               rsp_strobe,
   output logic [1:0]                         rsp_outcome,
   output logic                               rsp_entry_valid,
   output logic [kett_pkg::REASON_W-1:0]      rsp_entry_reason,
   output logic [kett_pkg::TAG_W-1:0]         rsp_entry_source,
   output logic [kett_pkg::TALLY_W-1:0]       rsp_entry_tally,
   output logic [kett_pkg::USED_W-1:0]        rsp_entries_used,
   output logic [kett_pkg::TALLY_W-1:0]       rsp_grand_total,
   output logic                               rsp_overflowed
);
   import kett_pkg::*;

   localparam int CNT_W = $clog2(TABLE_SLOTS + 1);
   localparam int IDX_W = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
   localparam int CMP_W = CNT_W + INDEX_W;
   localparam logic [CNT_W-1:0]    SLOTS_CNT  = CNT_W'(TABLE_SLOTS);
   localparam logic [REASON_W:0]   REASON_LIM = (REASON_W + 1)'(REASON_COUNT);

   typedef struct packed {
      logic [REASON_W-1:0] reason;
      logic [TAG_BITS-1:0] source;
      logic [TALLY_W-1:0]  tally;
   } entry_type;

   entry_type mem [TABLE_SLOTS];

   // Request latch
   op_type              op_ff;
   logic [REASON_W-1:0] reason_ff;
   logic [TAG_BITS-1:0] tag_ff;
   logic [INDEX_W-1:0]  idx_ff;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff     <= op_type'(req_operation);
         reason_ff <= req_reason_code;
         tag_ff    <= req_source_tag[TAG_BITS-1:0];
         idx_ff    <= req_entry_index;
      end
   end

   // Status counters
   logic [CNT_W-1:0]   used_ff;
   logic [TALLY_W-1:0] total_ff;
   logic               full_seen_ff;
   logic               count_event;

   assign count_event = cmd.bump | cmd.append | cmd.drop;

   always_ff @(posedge clock) begin
      if (reset || cmd.clear) begin
         used_ff      <= '0;
         total_ff     <= '0;
         full_seen_ff <= 1'b0;
      end else begin
         if (count_event) total_ff <= total_ff + TALLY_W'(1);
         if (cmd.append)  used_ff <= used_ff + CNT_W'(1);
         if (cmd.drop)    full_seen_ff <= 1'b1;
      end
   end

   // Scan pointer and read-valid tracking
   logic [CNT_W-1:0] ptr_ff;
   logic             rd_vld_ff;
   logic [IDX_W-1:0] rd_idx_ff;
   logic             ptr_more;
   logic             idx_ok;
   logic [CMP_W-1:0] idx_wide;

   assign idx_wide = CMP_W'(idx_ff);
   assign idx_ok   = idx_wide < CMP_W'(used_ff);
   assign ptr_more = ptr_ff < used_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         ptr_ff    <= '0;
         rd_vld_ff <= 1'b0;
      end else if (cmd.scan_start) begin
         ptr_ff    <= '0;
         rd_vld_ff <= 1'b0;
      end else if (cmd.scan_step) begin
         rd_vld_ff <= ptr_more;
         if (ptr_more) ptr_ff <= ptr_ff + CNT_W'(1);
      end else if (cmd.read_issue) begin
         rd_vld_ff <= idx_ok;
      end
   end

   // Slot memory: one write port, one registered read port
   logic             mem_re;
   logic [IDX_W-1:0] mem_raddr;
   logic             mem_we;
   logic [IDX_W-1:0] mem_waddr;
   entry_type        mem_wdata;
   entry_type        rd_ff;

   assign mem_re    = (cmd.scan_step && ptr_more) || (cmd.read_issue && idx_ok);
   assign mem_raddr = cmd.read_issue ? idx_wide[IDX_W-1:0] : ptr_ff[IDX_W-1:0];

   always_ff @(posedge clock) begin
      if (mem_re) begin
         rd_ff     <= mem[mem_raddr];
         rd_idx_ff <= mem_raddr;
      end
   end

   // Write data: saturating bump of the hit slot, or a fresh pair
   always_comb begin
      mem_we    = cmd.bump | cmd.append;
      mem_waddr = cmd.bump ? rd_idx_ff : used_ff[IDX_W-1:0];
      mem_wdata = rd_ff;
      if (cmd.bump) begin
         if (rd_ff.tally != '1) mem_wdata.tally = rd_ff.tally + TALLY_W'(1);
      end else begin
         mem_wdata.reason = reason_ff;
         mem_wdata.source = tag_ff;
         mem_wdata.tally  = TALLY_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) mem[mem_waddr] <= mem_wdata;
   end

   // Status to controller
   always_comb begin
      stat.op        = op_ff;
      stat.reason_ok = {1'b0, reason_ff} < REASON_LIM;
      stat.hit       = rd_vld_ff && (rd_ff.reason == reason_ff) && (rd_ff.source == tag_ff);
      stat.scan_done = !rd_vld_ff && !ptr_more;
      stat.full      = (used_ff == SLOTS_CNT);
   end

   // Outcome register
   outcome_type outcome_ff;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         outcome_ff <= OUT_EXISTING;
      end else if (cmd.outcome_wr) begin
         outcome_ff <= cmd.outcome;
      end
   end

   // Response transaction registers
   logic                 strobe_ff;
   logic [1:0]           outcome_o_ff;
   logic                 valid_o_ff;
   logic [REASON_W-1:0]  reason_o_ff;
   logic [TAG_W-1:0]     source_o_ff;
   logic [TALLY_W-1:0]   tally_o_ff;
   logic [USED_W-1:0]    used_o_ff;
   logic [TALLY_W-1:0]   total_o_ff;
   logic                 ovf_o_ff;
   logic                 show_entry;
   logic [CNT_W+USED_W-1:0] used_wide;

   assign show_entry = (op_ff == OP_READ) && rd_vld_ff;
   assign used_wide  = {{USED_W{1'b0}}, used_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= cmd.respond;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.respond) begin
         outcome_o_ff <= outcome_ff;
         valid_o_ff   <= show_entry;
         reason_o_ff  <= show_entry ? rd_ff.reason : '0;
         source_o_ff  <= show_entry ? TAG_W'(rd_ff.source) : '0;
         tally_o_ff   <= show_entry ? rd_ff.tally : '0;
         used_o_ff    <= used_wide[USED_W-1:0];
         total_o_ff   <= total_ff;
         ovf_o_ff     <= full_seen_ff;
      end
   end

   assign rsp_strobe       = strobe_ff;
   assign rsp_outcome      = outcome_o_ff;
   assign rsp_entry_valid  = valid_o_ff;
   assign rsp_entry_reason = reason_o_ff;
   assign rsp_entry_source = source_o_ff;
   assign rsp_entry_tally  = tally_o_ff;
   assign rsp_entries_used = used_o_ff;
   assign rsp_grand_total  = total_o_ff;
   assign rsp_overflowed   = ovf_o_ff;

endmodule
